// ===== design/vcr_pkg.sv =====
`default_nettype none

package vcr_pkg;

  localparam int unsigned PATTERN_BYTES = 8192;
  localparam int unsigned PAT_AW        = $clog2(PATTERN_BYTES);
  localparam int unsigned PAL_BYTES     = 32;
  localparam int unsigned PAL_AW        = $clog2(PAL_BYTES);

  typedef logic [1:0]  mirror_t;
  typedef logic [1:0]  kind_t;
  typedef logic [2:0]  reg_idx_t;
  typedef logic [7:0]  byte_t;
  typedef logic [13:0] vaddr_t;
  typedef logic [8:0]  count_t;

  localparam kind_t KIND_READ  = 2'd0;
  localparam kind_t KIND_WRITE = 2'd1;
  localparam kind_t KIND_TICK  = 2'd2;

  localparam reg_idx_t REG_CTRL   = 3'd0;
  localparam reg_idx_t REG_STATUS = 3'd2;
  localparam reg_idx_t REG_SCROLL = 3'd5;
  localparam reg_idx_t REG_ADDR   = 3'd6;
  localparam reg_idx_t REG_DATA   = 3'd7;

  localparam mirror_t MIRROR_LOWER = 2'd0;
  localparam mirror_t MIRROR_UPPER = 2'd1;
  localparam mirror_t MIRROR_HORIZ = 2'd2;
  localparam mirror_t MIRROR_VERT  = 2'd3;

  localparam vaddr_t NAME_BASE = 14'h2000;
  localparam vaddr_t PAL_BASE  = 14'h3f00;

  localparam count_t VBL_LINE   = 9'd241;
  localparam count_t VBL_DOT    = 9'd1;
  localparam count_t FRAME_LINE = 9'd239;
  localparam count_t FRAME_DOT  = 9'd256;

  typedef enum logic [1:0] {
    RGN_PAT  = 2'd0,
    RGN_NAME = 2'd1,
    RGN_PAL  = 2'd2
  } region_t;

  function automatic logic [10:0] name_index(vaddr_t a, mirror_t mode);
    logic [10:0] off;
    case (mode)
      MIRROR_LOWER: off = {1'b0, a[9:0]};
      MIRROR_UPPER: off = {1'b1, a[9:0]};
      MIRROR_HORIZ: off = {a[11], a[9:0]};
      MIRROR_VERT:  off = a[10:0];
      default:      off = a[10:0];
    endcase
    return off;
  endfunction

  function automatic logic [PAL_AW-1:0] palette_index(vaddr_t a);
    logic [PAL_AW-1:0] p;
    p = a[PAL_AW-1:0];
    if (p[4] && (p[1:0] == 2'b00)) begin
      p[4] = 1'b0;
    end
    return p;
  endfunction

  function automatic region_t region_of(vaddr_t a);
    region_t r;
    if (a < NAME_BASE) begin
      r = RGN_PAT;
    end else if (a < PAL_BASE) begin
      r = RGN_NAME;
    end else begin
      r = RGN_PAL;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== design/vcr_in_if.sv =====
`default_nettype none

interface vcr_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [2:0] reg_req;
  logic [7:0] wdata;

  modport source (output valid, kind, reg_req, wdata, input ready);
  modport sink (input valid, kind, reg_req, wdata, output ready);
endinterface

`default_nettype wire

// ===== design/vcr_out_if.sv =====
`default_nettype none

interface vcr_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] rdata;
  logic       nmi;
  logic       new_frame;

  modport source (output valid, rdata, nmi, new_frame, input ready);
  modport sink (input valid, rdata, nmi, new_frame, output ready);
endinterface

`default_nettype wire

// ===== design/vcr_ram.sv =====
`default_nettype none

module vcr_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// ===== design/video_chip_register_port_vram_core.sv =====
// Register port of a video chip with its video memory and frame timing.
// Input channel in_ch carries one item per handshake: a register read
// (kind 0), a register write (kind 1) or one dot tick (kind 2), with the
// register index in reg_req and the write byte in wdata. Every item gives
// exactly one item on out_ch: read data, the vblank interrupt pulse and the
// frame-end pulse. cfg_we/cfg_wdata set the nametable mirroring mode.
// Items pass the first-stage and output registers to out_ch.valid; one is
// taken every cycle while no clear runs and out_ch is not stalled. Pattern,
// nametable and palette memories are synchronous RAMs, read on acceptance;
// the registered RAM read sets the two-stage pipe, and the read buffer is
// updated in the second stage. After reset a clearing pass zeroes all three
// memories while in_ch.ready stays low; configuration writes are taken as
// ever. When out_ch is stalled one item waits in the output register and
// one in the second stage, and in_ch.ready then drops until out_ch drains.
`default_nettype none

module video_chip_register_port_vram_core #(
  parameter int unsigned NAME_BYTES      = 2048,
  parameter int unsigned DOTS_PER_LINE   = 341,
  parameter int unsigned LINES_PER_FRAME = 262
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             cfg_we,
  input  wire vcr_pkg::mirror_t cfg_wdata,
  vcr_in_if.sink                in_ch,
  vcr_out_if.source             out_ch
);

  import vcr_pkg::*;

  localparam int unsigned NAME_AW   = $clog2(NAME_BYTES);
  localparam count_t      LAST_DOT  = count_t'(DOTS_PER_LINE - 1);
  localparam count_t      LAST_LINE = count_t'(LINES_PER_FRAME - 1);
  localparam logic [PAT_AW-1:0] CLR_LAST = PAT_AW'(PATTERN_BYTES - 1);

  mirror_t            mirror_r;
  logic [15:0]        cur_addr_r, cur_addr_nxt;
  logic [14:0]        temp_addr_r, temp_addr_nxt;
  logic               toggle_r, toggle_nxt;
  byte_t              rbuf_r, rbuf_nxt;
  logic               step_row_r, step_row_nxt;
  logic               nmi_en_r, nmi_en_nxt;
  logic               vblank_r, vblank_nxt;
  count_t             dot_r, dot_nxt;
  count_t             line_r, line_nxt;
  logic               clr_busy_r;
  logic [PAT_AW-1:0]  clr_cnt_r;

  logic               s1_valid_r, s1_valid_nxt;
  logic               s1_drd_r;
  region_t            s1_rgn_r;
  byte_t              s1_rdata_r;
  logic               s1_nmi_r;
  logic               s1_frame_r;
  byte_t              s1_rdata_nxt;
  logic               s1_nmi_nxt;
  logic               s1_frame_nxt;

  logic               out_valid_r, out_valid_nxt;
  byte_t              out_rdata_r;
  logic               out_nmi_r;
  logic               out_frame_r;
  byte_t              res_rdata;

  logic               accept, s1_adv, s1_move;
  logic               rd_data, wr_data;
  vaddr_t             mem_a;
  region_t            rgn;
  logic [15:0]        step;

  byte_t              pat_q, name_q, pal_q;
  logic               pat_we, name_we, pal_we;
  logic [PAT_AW-1:0]  pat_waddr;
  logic [NAME_AW-1:0] name_addr, name_waddr;
  logic [PAL_AW-1:0]  pal_addr, pal_waddr;
  byte_t              mem_wdata;

  assign s1_adv      = !out_valid_r || out_ch.ready;
  assign s1_move     = s1_valid_r && s1_adv;
  assign in_ch.ready = !clr_busy_r && (!s1_valid_r || s1_adv);
  assign accept      = in_ch.valid && in_ch.ready;

  assign mem_a   = cur_addr_r[13:0];
  assign rgn     = region_of(mem_a);
  assign step    = step_row_r ? 16'd32 : 16'd1;
  assign rd_data = accept && (in_ch.kind == KIND_READ) && (in_ch.reg_req == REG_DATA);
  assign wr_data = accept && (in_ch.kind == KIND_WRITE) && (in_ch.reg_req == REG_DATA);

  assign name_addr = NAME_AW'(name_index(mem_a, mirror_r));
  assign pal_addr  = palette_index(mem_a);

  assign pat_we     = clr_busy_r || (wr_data && (rgn == RGN_PAT));
  assign name_we    = clr_busy_r || (wr_data && (rgn == RGN_NAME));
  assign pal_we     = clr_busy_r || (wr_data && (rgn == RGN_PAL));
  assign pat_waddr  = clr_busy_r ? clr_cnt_r : mem_a[PAT_AW-1:0];
  assign name_waddr = clr_busy_r ? clr_cnt_r[NAME_AW-1:0] : name_addr;
  assign pal_waddr  = clr_busy_r ? clr_cnt_r[PAL_AW-1:0] : pal_addr;
  assign mem_wdata  = clr_busy_r ? 8'h00 : in_ch.wdata;

  vcr_ram #(.WIDTH(8), .DEPTH(PATTERN_BYTES)) u_pat_ram (
    .clk   (clk),
    .we    (pat_we),
    .waddr (pat_waddr),
    .wdata (mem_wdata),
    .re    (rd_data),
    .raddr (mem_a[PAT_AW-1:0]),
    .rdata (pat_q)
  );

  vcr_ram #(.WIDTH(8), .DEPTH(NAME_BYTES)) u_name_ram (
    .clk   (clk),
    .we    (name_we),
    .waddr (name_waddr),
    .wdata (mem_wdata),
    .re    (rd_data),
    .raddr (name_addr),
    .rdata (name_q)
  );

  vcr_ram #(.WIDTH(8), .DEPTH(PAL_BYTES)) u_pal_ram (
    .clk   (clk),
    .we    (pal_we),
    .waddr (pal_waddr),
    .wdata (mem_wdata),
    .re    (rd_data),
    .raddr (pal_addr),
    .rdata (pal_q)
  );

  // first stage: register state and timing
  always_comb begin
    cur_addr_nxt  = cur_addr_r;
    temp_addr_nxt = temp_addr_r;
    toggle_nxt    = toggle_r;
    step_row_nxt  = step_row_r;
    nmi_en_nxt    = nmi_en_r;
    vblank_nxt    = vblank_r;
    dot_nxt       = dot_r;
    line_nxt      = line_r;
    s1_rdata_nxt  = 8'h00;
    s1_nmi_nxt    = 1'b0;
    s1_frame_nxt  = 1'b0;
    if (accept) begin
      case (in_ch.kind)
        KIND_READ: begin
          if (in_ch.reg_req == REG_STATUS) begin
            s1_rdata_nxt = {vblank_r, 7'b0};
            vblank_nxt   = 1'b0;
            toggle_nxt   = 1'b0;
          end else if (in_ch.reg_req == REG_DATA) begin
            cur_addr_nxt = cur_addr_r + step;
          end
        end
        KIND_WRITE: begin
          case (in_ch.reg_req)
            REG_CTRL: begin
              step_row_nxt = in_ch.wdata[2];
              nmi_en_nxt   = in_ch.wdata[7];
            end
            REG_SCROLL: begin
              if (!toggle_r) begin
                temp_addr_nxt[4:0] = in_ch.wdata[7:3];
              end else begin
                temp_addr_nxt[14:12] = in_ch.wdata[2:0];
                temp_addr_nxt[9:5]   = in_ch.wdata[7:3];
              end
              toggle_nxt = !toggle_r;
            end
            REG_ADDR: begin
              if (!toggle_r) begin
                temp_addr_nxt[14:8] = {1'b0, in_ch.wdata[5:0]};
              end else begin
                temp_addr_nxt[7:0] = in_ch.wdata;
                cur_addr_nxt       = {1'b0, temp_addr_r[14:8], in_ch.wdata};
              end
              toggle_nxt = !toggle_r;
            end
            REG_DATA: begin
              cur_addr_nxt = cur_addr_r + step;
            end
            default: begin
            end
          endcase
        end
        KIND_TICK: begin
          s1_frame_nxt = (line_r == FRAME_LINE) && (dot_r == FRAME_DOT);
          if ((line_r == VBL_LINE) && (dot_r == VBL_DOT)) begin
            vblank_nxt = 1'b1;
            s1_nmi_nxt = nmi_en_r;
          end
          if ((line_r == LAST_LINE) && (dot_r == VBL_DOT)) begin
            vblank_nxt = 1'b0;
          end
          if (dot_r == LAST_DOT) begin
            dot_nxt  = '0;
            line_nxt = (line_r == LAST_LINE) ? count_t'(0) : line_r + 9'd1;
          end else begin
            dot_nxt = dot_r + 9'd1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // second stage: memory data and read buffer
  always_comb begin
    res_rdata = s1_rdata_r;
    rbuf_nxt  = rbuf_r;
    if (s1_drd_r) begin
      case (s1_rgn_r)
        RGN_PAL: begin
          res_rdata = {2'b00, pal_q[5:0]};
          rbuf_nxt  = name_q;
        end
        RGN_NAME: begin
          res_rdata = rbuf_r;
          rbuf_nxt  = name_q;
        end
        RGN_PAT: begin
          res_rdata = rbuf_r;
          rbuf_nxt  = pat_q;
        end
        default: begin
          res_rdata = rbuf_r;
        end
      endcase
    end
  end

  always_comb begin
    s1_valid_nxt  = s1_valid_r;
    out_valid_nxt = out_valid_r;
    if (!s1_valid_r || s1_adv) begin
      s1_valid_nxt = accept;
    end
    if (s1_adv) begin
      out_valid_nxt = s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mirror_r    <= MIRROR_VERT;
      cur_addr_r  <= '0;
      temp_addr_r <= '0;
      toggle_r    <= 1'b0;
      rbuf_r      <= '0;
      step_row_r  <= 1'b0;
      nmi_en_r    <= 1'b0;
      vblank_r    <= 1'b0;
      dot_r       <= '0;
      line_r      <= VBL_LINE;
      clr_busy_r  <= 1'b1;
      clr_cnt_r   <= '0;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        mirror_r <= cfg_wdata;
      end
      cur_addr_r  <= cur_addr_nxt;
      temp_addr_r <= temp_addr_nxt;
      toggle_r    <= toggle_nxt;
      step_row_r  <= step_row_nxt;
      nmi_en_r    <= nmi_en_nxt;
      vblank_r    <= vblank_nxt;
      dot_r       <= dot_nxt;
      line_r      <= line_nxt;
      if (s1_move) begin
        rbuf_r <= rbuf_nxt;
      end
      if (clr_busy_r) begin
        clr_cnt_r <= clr_cnt_r + 1'b1;
        if (clr_cnt_r == CLR_LAST) begin
          clr_busy_r <= 1'b0;
        end
      end
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_drd_r   <= rd_data;
      s1_rgn_r   <= rgn;
      s1_rdata_r <= s1_rdata_nxt;
      s1_nmi_r   <= s1_nmi_nxt;
      s1_frame_r <= s1_frame_nxt;
    end
    if (s1_move) begin
      out_rdata_r <= res_rdata;
      out_nmi_r   <= s1_nmi_r;
      out_frame_r <= s1_frame_r;
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.rdata     = out_rdata_r;
  assign out_ch.nmi       = out_nmi_r;
  assign out_ch.new_frame = out_frame_r;

  a_no_accept_while_clearing : assert property (@(posedge clk) disable iff (!rst_n)
    clr_busy_r |-> !in_ch.ready)
    else $error("item taken during memory clear");

  a_hold_when_full : assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && out_valid_r && !out_ch.ready) |-> !in_ch.ready)
    else $error("item taken while pipe is full");

  a_dot_in_range : assert property (@(posedge clk) disable iff (!rst_n)
    dot_r <= LAST_DOT)
    else $error("dot count out of range");

  a_vblank_set : assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (in_ch.kind == KIND_TICK) && (line_r == VBL_LINE) && (dot_r == VBL_DOT))
    |=> vblank_r)
    else $error("vblank not raised");

  a_pulses_exclusive : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_nmi_r && out_frame_r))
    else $error("nmi and frame end on one item");

endmodule

`default_nettype wire
